### src/q15mpo_pkg.sv
// shared types, constants and sine table generator for the q15 multiwave oscillator
`default_nettype none
package q15mpo_pkg;

  localparam int Q15_W     = 16;
  localparam int MODE_W    = 2;
  localparam int WAVE_W    = 3;
  localparam int RATE_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic signed [Q15_W-1:0] Q15_MAX    = 16'sh7FFF;
  localparam logic signed [Q15_W-1:0] Q15_MIN    = 16'sh8000;
  localparam logic signed [Q15_W-1:0] HALF_SCALE = 16'sh4000;
  localparam logic signed [Q15_W-1:0] ZERO_LEVEL = 16'sh0000;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_RAMP   = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd3;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_IDX,
    ST_IDX_B,
    ST_DIFF,
    ST_INTERP,
    ST_SCALE,
    ST_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // table entry from a 32-bit cycle fraction, only evaluated on constants
  function automatic logic signed [Q15_W-1:0] sine_entry(input logic [63:0] frac);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    quad = frac[31:30];
    r = {34'd0, frac[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -(v[Q15_W-1:0]) : v[Q15_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/q15mpo_if.sv
// request, result and register write channel interfaces
`default_nettype none
interface q15mpo_req_if;
  import q15mpo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [Q15_W-1:0] phase_value;
  modport source(output valid, mode, phase_value, input ready);
  modport sink(input valid, mode, phase_value, output ready);
endinterface

interface q15mpo_rsp_if;
  import q15mpo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [Q15_W-1:0] sample;
  logic                    cycle_end;
  logic                    rise_end;
  logic                    rising_half;
  modport source(output valid, sample, cycle_end, rise_end, rising_half, input ready);
  modport sink(input valid, sample, cycle_end, rise_end, rising_half, output ready);
endinterface

interface q15mpo_cfg_if;
  import q15mpo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [Q15_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/q15mpo_mul.sv
// shared signed multiplier with registered product
`default_nettype none
module q15mpo_mul (
  input  wire logic                                  clk,
  input  wire q15mpo_pkg::mul_req_t                  req,
  output logic signed [q15mpo_pkg::PROD_W-1:0]       prod
);
  import q15mpo_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule
`default_nettype wire

### src/q15mpo_sine_rom.sv
// sine lookup rom with registered read
`default_nettype none
module q15mpo_sine_rom #(
  parameter int Depth = 256
) (
  input  wire logic                                 clk,
  input  wire logic [$clog2(Depth)-1:0]             addr,
  output logic signed [q15mpo_pkg::Q15_W-1:0]       data
);
  import q15mpo_pkg::*;

  logic signed [Q15_W-1:0] tbl [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic [63:0] Frac = (64'(g) << 32) / 64'(Depth);
    assign tbl[g] = sine_entry(Frac);
  end

  always_ff @(posedge clk) begin
    data <= tbl[addr];
  end

endmodule
`default_nettype wire

### src/q15_multiwave_phase_oscillator.sv
// q15 multiwave phase oscillator top level with sequencer and datapath
//
// req carries a mode and a phase word. mode 0 asks for one sample, mode 1
// adds phase_value to the phase accumulator, mode 2 loads it, mode 3 is
// dropped. only mode 0 produces a word on rsp: the sample of the current
// phase, then the phase advances by min(2*rate_word, 32767).
// cfg writes wave_select, gain, duty_threshold and rate_word by index 0..3;
// it is always ready and is meant to be written while the block is idle.
// one shared 17x17 multiplier does the table position, the interpolation
// and the gain scaling in turn: a sine sample passes ST_IDX, ST_IDX_B,
// ST_DIFF and ST_INTERP, and ST_SCALE and ST_SAT are skipped at full
// scale gain; req is ready again once the result is registered, and
// a phase command keeps the block idle, so req stays ready.
// the result waits in an output register; while rsp is stalled a finished
// sample is held back and req stays not ready.
// reset (rst, synchronous) restores the register defaults, sets the phase
// to -32768 and empties the output register.
`default_nettype none
module q15_multiwave_phase_oscillator #(
  parameter int SINE_TABLE_SIZE = 256
) (
  input wire logic clk,
  input wire logic rst,
  q15mpo_req_if.sink   req,
  q15mpo_rsp_if.source rsp,
  q15mpo_cfg_if.sink   cfg
);
  import q15mpo_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_SIZE);

  state_t state;
  state_t state_next;

  logic [WAVE_W-1:0]       wave_sel;
  logic signed [Q15_W-1:0] gain;
  logic signed [Q15_W-1:0] duty;
  logic [RATE_W-1:0]       rate;
  logic signed [Q15_W-1:0] phase;
  logic                    out_valid;

  logic signed [Q15_W-1:0] smp;
  logic [IdxW-1:0]         idx_r;
  logic [14:0]             frac_r;
  logic signed [Q15_W-1:0] a_r;

  logic signed [Q15_W-1:0] out_sample;
  logic                    out_cycle;
  logic                    out_rise;
  logic                    out_half;

  logic signed [Q15_W-1:0]  p_half;
  logic [14:0]              sine_x;
  logic signed [Q15_W-1:0]  shaped;
  logic [Q15_W-1:0]         inc;
  logic signed [Q15_W-1:0]  np;
  logic [IdxW-1:0]          rom_addr;
  logic signed [Q15_W-1:0]  rom_data;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic                     accept;
  logic                     out_load;
  logic                     full_gain;

  q15mpo_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  q15mpo_sine_rom #(
    .Depth (SINE_TABLE_SIZE)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign full_gain = (gain == Q15_MAX);
  assign out_load  = (state == ST_OUT) && (!out_valid || rsp.ready);

  assign rsp.valid       = out_valid;
  assign rsp.sample      = out_sample;
  assign rsp.cycle_end   = out_cycle;
  assign rsp.rise_end    = out_rise;
  assign rsp.rising_half = out_half;

  // phase / 2 toward zero, offset into one cycle fraction
  assign p_half = (phase >>> 1) + $signed(Q15_W'(phase[Q15_W-1] & phase[0]));
  assign sine_x = 15'(p_half + HALF_SCALE);
  assign inc    = rate[RATE_W-1] ? Q15_W'(Q15_MAX) : {rate, 1'b0};
  assign np     = phase + inc;
  assign prod_q = prod >>> 15;

  always_comb begin
    case (wave_sel)
      WAVE_TRI: begin
        if (phase[Q15_W-1]) begin
          shaped = (phase + HALF_SCALE) <<< 1;
        end else begin
          shaped = (HALF_SCALE - phase) <<< 1;
        end
      end
      WAVE_SAW:    shaped = -phase;
      WAVE_RAMP:   shaped = phase;
      WAVE_SQUARE: shaped = (phase < duty) ? Q15_MAX : Q15_MIN;
      default:     shaped = ZERO_LEVEL;
    endcase
  end

  always_comb begin
    if (state == ST_IDX) begin
      rom_addr = prod[15 +: IdxW];
    end else if (idx_r == IdxW'(SINE_TABLE_SIZE - 1)) begin
      rom_addr = '0;
    end else begin
      rom_addr = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_req.en  = 1'b0;
    mul_req.a   = '0;
    mul_req.b   = '0;
    case (state)
      ST_IDLE: begin
        if (accept && (req.mode == MODE_SAMPLE)) begin
          state_next = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        if (wave_sel == WAVE_SINE) begin
          mul_req.en = 1'b1;
          mul_req.a  = {2'b00, sine_x};
          mul_req.b  = MUL_W'(SINE_TABLE_SIZE);
          state_next = ST_IDX;
        end else begin
          state_next = full_gain ? ST_OUT : ST_SCALE;
        end
      end
      ST_IDX:   state_next = ST_IDX_B;
      ST_IDX_B: state_next = ST_DIFF;
      ST_DIFF: begin
        mul_req.en = 1'b1;
        mul_req.a  = {rom_data[Q15_W-1], rom_data} - {a_r[Q15_W-1], a_r};
        mul_req.b  = {2'b00, frac_r};
        state_next = ST_INTERP;
      end
      ST_INTERP: state_next = full_gain ? ST_OUT : ST_SCALE;
      ST_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = {smp[Q15_W-1], smp};
        mul_req.b  = {gain[Q15_W-1], gain};
        state_next = ST_SAT;
      end
      ST_SAT: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_sel  <= WAVE_SINE;
      gain      <= Q15_MAX;
      duty      <= ZERO_LEVEL;
      rate      <= '0;
      phase     <= Q15_MIN;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WAVE: wave_sel <= cfg.data[WAVE_W-1:0];
          REG_GAIN: gain     <= cfg.data;
          REG_DUTY: duty     <= cfg.data;
          REG_RATE: rate     <= cfg.data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (req.mode)
          MODE_OFFSET: phase <= phase + req.phase_value;
          MODE_LOAD:   phase <= req.phase_value;
          default: ;
        endcase
      end
      if (out_load) begin
        phase     <= np;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SHAPE: smp <= shaped;
      ST_IDX: begin
        idx_r  <= prod[15 +: IdxW];
        frac_r <= prod[14:0];
      end
      ST_IDX_B:  a_r <= rom_data;
      ST_INTERP: smp <= a_r + prod_q[Q15_W-1:0];
      ST_SAT: begin
        if (prod_q > PROD_W'(32767)) begin
          smp <= Q15_MAX;
        end else begin
          smp <= prod_q[Q15_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_sample <= smp;
          out_cycle  <= (phase > np);
          out_rise   <= phase[Q15_W-1] && !np[Q15_W-1];
          out_half   <= np[Q15_W-1];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
